/* rtl/two_lane_queue_admission_assert.svh */
// Assertion macros shared by the queue admission RTL.
// Each macro takes a label, the clock, the active-low reset, a condition
// and a consequence.
`ifndef TWO_LANE_QUEUE_ADMISSION_ASSERT_SVH
`define TWO_LANE_QUEUE_ADMISSION_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TLQA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tlqa: same-cycle check failed");
// Next-cycle implication.
`define TLQA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tlqa: next-cycle check failed");
`else
`define TLQA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define TLQA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/tlqa_pkg.sv */
`timescale 1ns / 1ps
package tlqa_pkg;

    // default geometry
    localparam int LANE_DEPTH_DEF = 64;
    localparam int SIZE_BITS_DEF  = 16;

    // fixed field widths
    localparam int MSG_W     = 16;
    localparam int BYTES_W   = 32;
    localparam int RATE_W    = 32;
    localparam int LIMIT_W   = 8;
    localparam int FRAC_W    = 16;
    localparam int FRAC1_W   = FRAC_W + 1;
    localparam int MUL_A_W   = 32;
    localparam int PROD_W    = MUL_A_W + FRAC1_W;
    localparam int RETRY_NUM_W = 26;
    localparam int DIV_NUM_W = RETRY_NUM_W + FRAC_W;
    localparam int DIV_DEN_W = RATE_W;

    localparam logic [FRAC1_W-1:0] Q16_ONE     = FRAC1_W'(65536);
    localparam logic [FRAC1_W-1:0] RETRY_SCALE = FRAC1_W'(1000);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LIMIT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_RESERVE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNRELIABLE_HEADROOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_ALPHA         = 3'd4;

    localparam logic [LIMIT_W-1:0] MESSAGE_LIMIT_RST       = 8'd64;
    localparam logic [BYTES_W-1:0] BYTE_LIMIT_RST          = 32'd1048576;
    localparam logic [LIMIT_W-1:0] CONTROL_RESERVE_RST     = 8'd8;
    localparam logic [FRAC_W-1:0]  UNRELIABLE_HEADROOM_RST = 16'd6554;
    localparam logic [FRAC_W-1:0]  DRAIN_ALPHA_RST         = 16'd13107;

    // command and lane codes
    localparam logic CMD_ENQ   = 1'b0;
    localparam logic CMD_DEQ   = 1'b1;
    localparam logic LANE_CTL  = 1'b0;
    localparam logic LANE_DATA = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/tlqa_ram.sv */
`timescale 1ns / 1ps
module tlqa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tlqa_div.sv */
`timescale 1ns / 1ps
module tlqa_div
    import tlqa_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_stat        o_stat,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_trial;
    logic             w_ge;
    logic [DEN_W-1:0] w_rem_next;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_trial    = {r_rem, r_num[NUM_W-1]};
        w_ge       = (w_trial >= {1'b0, r_den});
        w_rem_next = w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend register fills with quotient bits as it shifts
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_rem_next;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_num;

endmodule

/* rtl/two_lane_queue_admission.sv */
// Two-lane queue admission controller. Each input word is either an enqueue
// request (admit or reject a message of msg_bytes into the control or data
// lane) or a dequeue request (pop the control lane first, else the data
// lane); each input word yields exactly one result word carrying the decision,
// retry hint, dequeued entry and the per-lane counts, byte totals and drain
// rate after the step. One word is in work at a time: the block raises
// o_in_stall from accept until the result is loaded into the output register,
// and a waiting result does not block the next accept. A data enqueue uses
// the shared 42-step restoring divider for the data byte limit, and a rejected
// nonempty enqueue with a nonzero drain rate uses it again for the retry hint;
// an unreliable data enqueue also applies the headroom cut. Every scaling step
// goes through a shared 32x17 multiplier, one product a cycle.
// Lane sizes live in two RAMs of LANE_DEPTH entries with registered read.
`timescale 1ns / 1ps
`include "two_lane_queue_admission_assert.svh"
module two_lane_queue_admission
    import tlqa_pkg::*;
#(
    parameter int LANE_DEPTH = LANE_DEPTH_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic [MSG_W-1:0]                  i_msg_bytes,
    input  logic                              i_is_control,
    input  logic                              i_is_reliable,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_admitted,
    output logic [RATE_W-1:0]                 o_retry_ms,
    output logic                              o_deq_valid,
    output logic                              o_deq_lane,
    output logic [MSG_W-1:0]                  o_deq_bytes,
    output logic [$clog2(LANE_DEPTH+1)-1:0]   o_control_count,
    output logic [$clog2(LANE_DEPTH+1)-1:0]   o_data_count,
    output logic [BYTES_W-1:0]                o_control_byte_total,
    output logic [BYTES_W-1:0]                o_data_byte_total,
    output logic [RATE_W-1:0]                 o_drain_rate,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [CFG_DATA_W-1:0]             i_cfg_data
);

    localparam int IW = $clog2(LANE_DEPTH);
    localparam int CW = $clog2(LANE_DEPTH + 1);
    localparam logic [CW-1:0] DepthCnt = CW'(LANE_DEPTH);
    localparam logic [IW:0]   DepthIdx = (IW+1)'(LANE_DEPTH);
    localparam logic [IW-1:0] LastIdx  = IW'(LANE_DEPTH - 1);
    localparam logic [MSG_W-1:0] SzMask = (SIZE_BITS >= MSG_W) ? {MSG_W{1'b1}} :
                                          MSG_W'((17'd1 << SIZE_BITS) - 17'd1);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EB_MUL = 4'd1;
    localparam logic [3:0] S_EB_DGO = 4'd2;
    localparam logic [3:0] S_EB_DWT = 4'd3;
    localparam logic [3:0] S_UR_M1  = 4'd4;
    localparam logic [3:0] S_UR_M2  = 4'd5;
    localparam logic [3:0] S_UR_M3  = 4'd6;
    localparam logic [3:0] S_ADM    = 4'd7;
    localparam logic [3:0] S_RT_M   = 4'd8;
    localparam logic [3:0] S_RT_DGO = 4'd9;
    localparam logic [3:0] S_RT_DWT = 4'd10;
    localparam logic [3:0] S_DQ_RD  = 4'd11;
    localparam logic [3:0] S_DQ_M2  = 4'd12;
    localparam logic [3:0] S_DQ_SUM = 4'd13;
    localparam logic [3:0] S_COMMIT = 4'd14;

    // control state
    logic [3:0]          r_state;
    logic                r_out_valid;
    logic [LIMIT_W-1:0]  r_msg_limit;
    logic [BYTES_W-1:0]  r_byte_limit;
    logic [LIMIT_W-1:0]  r_ctl_reserve;
    logic [FRAC_W-1:0]   r_ur_headroom;
    logic [FRAC_W-1:0]   r_drain_alpha;
    logic [IW-1:0]       r_c_head;
    logic [IW-1:0]       r_d_head;
    logic [CW-1:0]       r_c_count;
    logic [CW-1:0]       r_d_count;
    logic [BYTES_W-1:0]  r_c_bytes;
    logic [BYTES_W-1:0]  r_d_bytes;
    logic [RATE_W-1:0]   r_rate;

    // per-word working registers
    logic                r_cmd;
    logic [MSG_W-1:0]    r_sz;
    logic                r_ctl;
    logic                r_rel;
    logic                r_lane;
    logic                r_dq_valid;
    logic                r_adm;
    logic [RATE_W-1:0]   r_retry;
    logic [LIMIT_W-1:0]  r_lim_msgs;
    logic [BYTES_W-1:0]  r_lim_bytes;
    logic [MSG_W-1:0]    r_s;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-2:0]   r_t1;
    logic [RATE_W-1:0]   r_new_rate;

    // output payload
    logic                r_out_admitted;
    logic [RATE_W-1:0]   r_out_retry;
    logic                r_out_deq_valid;
    logic                r_out_deq_lane;
    logic [MSG_W-1:0]    r_out_deq_bytes;

    logic                w_in_accept;
    logic                w_commit;
    logic [MSG_W-1:0]    w_sz_in;
    logic [LIMIT_W-1:0]  w_eff_msgs;
    logic [FRAC1_W-1:0]  w_keep;
    logic [FRAC1_W-1:0]  w_alpha_keep;
    logic [SIZE_BITS-1:0] w_c_rd;
    logic [SIZE_BITS-1:0] w_d_rd;
    logic [MSG_W-1:0]    w_rd16;
    logic [MUL_A_W-1:0]  w_mul_a;
    logic [FRAC1_W-1:0]  w_mul_b;
    logic [BYTES_W+1:0]  w_tot_bytes;
    logic [CW:0]         w_tot_msgs;
    logic [BYTES_W:0]    w_dat_bytes;
    logic                w_ctl_adm;
    logic                w_dat_adm;
    logic                w_adm;
    logic [IW:0]         w_slot_sum;
    logic [IW-1:0]       w_slot;
    logic [IW-1:0]       w_c_head_inc;
    logic [IW-1:0]       w_d_head_inc;
    logic                w_enq_write;
    logic [PROD_W-1:0]   w_rate_sum;
    logic [RATE_W-1:0]   w_rate_sat;
    logic                w_div_start;
    logic [DIV_NUM_W-1:0] w_div_num;
    logic [DIV_DEN_W-1:0] w_div_den;
    t_div_stat           w_div_stat;
    logic [DIV_NUM_W-1:0] w_div_quo;
    logic [RATE_W-1:0]   w_retry_sat;

    // handshake: take a word only when the sequencer is idle
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && (r_state == S_IDLE);
    // load a finished result once the output register is free or draining
    assign w_commit    = (r_state == S_COMMIT) && (!r_out_valid || !i_out_stall);

    // trim the size to the stored width
    assign w_sz_in = i_msg_bytes & SzMask;

    // data limits before headroom: message limit less the control reserve
    assign w_eff_msgs   = (r_msg_limit > r_ctl_reserve) ? (r_msg_limit - r_ctl_reserve) : '0;
    assign w_keep       = Q16_ONE - FRAC1_W'(r_ur_headroom);
    assign w_alpha_keep = Q16_ONE - FRAC1_W'(r_drain_alpha);

    assign w_rd16 = (r_lane == LANE_CTL) ? MSG_W'(w_c_rd) : MSG_W'(w_d_rd);

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_EB_MUL: begin
                w_mul_a = r_byte_limit;
                w_mul_b = FRAC1_W'(w_eff_msgs);
            end
            S_UR_M1: begin
                w_mul_a = MUL_A_W'(r_lim_msgs);
                w_mul_b = w_keep;
            end
            S_UR_M2: begin
                w_mul_a = r_lim_bytes;
                w_mul_b = w_keep;
            end
            S_RT_M: begin
                w_mul_a = MUL_A_W'(r_sz);
                w_mul_b = RETRY_SCALE;
            end
            S_DQ_RD: begin
                w_mul_a = MUL_A_W'(w_rd16);
                w_mul_b = FRAC1_W'(r_drain_alpha);
            end
            S_DQ_M2: begin
                w_mul_a = r_rate;
                w_mul_b = w_alpha_keep;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // admission checks against the live lane state
    always_comb begin
        w_tot_bytes = (BYTES_W+2)'(r_c_bytes) + (BYTES_W+2)'(r_d_bytes) + (BYTES_W+2)'(r_sz);
        w_tot_msgs  = (CW+1)'(r_c_count) + (CW+1)'(r_d_count);
        w_ctl_adm   = (r_c_count < DepthCnt)
                   && (w_tot_bytes <= (BYTES_W+2)'(r_byte_limit))
                   && ((32'(r_c_count) < 32'(r_ctl_reserve))
                       || (32'(w_tot_msgs) < 32'(r_msg_limit)));
        w_dat_bytes = (BYTES_W+1)'(r_d_bytes) + (BYTES_W+1)'(r_sz);
        w_dat_adm   = (r_d_count < DepthCnt)
                   && (32'(r_d_count) < 32'(r_lim_msgs))
                   && (w_dat_bytes <= (BYTES_W+1)'(r_lim_bytes));
        w_adm       = r_ctl ? w_ctl_adm : w_dat_adm;
    end

    // tail slot of the target lane and head advance with wrap
    always_comb begin
        if (r_lane == LANE_CTL) begin
            w_slot_sum = (IW+1)'(r_c_head) + (IW+1)'(r_c_count);
        end else begin
            w_slot_sum = (IW+1)'(r_d_head) + (IW+1)'(r_d_count);
        end
        w_slot       = (w_slot_sum >= DepthIdx) ? IW'(w_slot_sum - DepthIdx) : IW'(w_slot_sum);
        w_c_head_inc = (r_c_head == LastIdx) ? '0 : r_c_head + IW'(1);
        w_d_head_inc = (r_d_head == LastIdx) ? '0 : r_d_head + IW'(1);
    end

    assign w_enq_write = w_commit && (r_cmd == CMD_ENQ) && r_adm;

    // drain average: alpha * size + (1 - alpha) * rate, saturated
    assign w_rate_sum = PROD_W'(r_t1) + PROD_W'(r_prod[PROD_W-2:FRAC_W]);
    assign w_rate_sat = (|w_rate_sum[PROD_W-1:RATE_W]) ? {RATE_W{1'b1}} : w_rate_sum[RATE_W-1:0];

    // shared divider: data byte limit, then retry hint
    assign w_div_start = (r_state == S_EB_DGO) || (r_state == S_RT_DGO);
    assign w_div_num   = (r_state == S_RT_DGO) ? {r_prod[RETRY_NUM_W-1:0], FRAC_W'(0)}
                                               : DIV_NUM_W'(r_prod[BYTES_W+LIMIT_W-1:0]);
    assign w_div_den   = (r_state == S_RT_DGO) ? r_rate : DIV_DEN_W'(r_msg_limit);
    assign w_retry_sat = (|w_div_quo[DIV_NUM_W-1:RATE_W]) ? {RATE_W{1'b1}}
                                                          : w_div_quo[RATE_W-1:0];

    tlqa_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_stat  (w_div_stat),
        .o_quo   (w_div_quo)
    );

    tlqa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (LANE_DEPTH)
    ) u_ctl_ram (
        .i_clk   (i_clk),
        .i_we    (w_enq_write && (r_lane == LANE_CTL)),
        .i_waddr (w_slot),
        .i_wdata (SIZE_BITS'(r_sz)),
        .i_raddr (r_c_head),
        .o_rdata (w_c_rd)
    );

    tlqa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (LANE_DEPTH)
    ) u_dat_ram (
        .i_clk   (i_clk),
        .i_we    (w_enq_write && (r_lane == LANE_DATA)),
        .i_waddr (w_slot),
        .i_wdata (SIZE_BITS'(r_sz)),
        .i_raddr (r_d_head),
        .o_rdata (w_d_rd)
    );

    // sequencer, configuration and lane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_msg_limit   <= MESSAGE_LIMIT_RST;
            r_byte_limit  <= BYTE_LIMIT_RST;
            r_ctl_reserve <= CONTROL_RESERVE_RST;
            r_ur_headroom <= UNRELIABLE_HEADROOM_RST;
            r_drain_alpha <= DRAIN_ALPHA_RST;
            r_c_head      <= '0;
            r_d_head      <= '0;
            r_c_count     <= '0;
            r_d_count     <= '0;
            r_c_bytes     <= '0;
            r_d_bytes     <= '0;
            r_rate        <= '0;
        end else begin
            // register writes; unknown indexes drop
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MESSAGE_LIMIT:       r_msg_limit   <= i_cfg_data[LIMIT_W-1:0];
                    CFG_BYTE_LIMIT:          r_byte_limit  <= i_cfg_data[BYTES_W-1:0];
                    CFG_CONTROL_RESERVE:     r_ctl_reserve <= i_cfg_data[LIMIT_W-1:0];
                    CFG_UNRELIABLE_HEADROOM: r_ur_headroom <= i_cfg_data[FRAC_W-1:0];
                    CFG_DRAIN_ALPHA:         r_drain_alpha <= i_cfg_data[FRAC_W-1:0];
                    default: ;
                endcase
            end

            // release the output word once taken
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        if (i_command == CMD_DEQ) begin
                            r_state <= ((r_c_count != '0) || (r_d_count != '0)) ? S_DQ_RD
                                                                               : S_COMMIT;
                        end else if (i_is_control) begin
                            r_state <= S_ADM;
                        end else begin
                            r_state <= S_EB_MUL;
                        end
                    end
                end
                // a zero message limit leaves both data limits at zero
                S_EB_MUL: r_state <= (r_msg_limit == '0) ? S_ADM : S_EB_DGO;
                S_EB_DGO: r_state <= S_EB_DWT;
                S_EB_DWT: begin
                    if (w_div_stat.done) begin
                        r_state <= r_rel ? S_ADM : S_UR_M1;
                    end
                end
                S_UR_M1: r_state <= S_UR_M2;
                S_UR_M2: r_state <= S_UR_M3;
                S_UR_M3: r_state <= S_ADM;
                S_ADM: begin
                    // no hint to compute when admitted, idle drain or empty message
                    if (w_adm || (r_rate == '0) || (r_sz == '0)) begin
                        r_state <= S_COMMIT;
                    end else begin
                        r_state <= S_RT_M;
                    end
                end
                S_RT_M:   r_state <= S_RT_DGO;
                S_RT_DGO: r_state <= S_RT_DWT;
                S_RT_DWT: begin
                    if (w_div_stat.done) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_DQ_RD:  r_state <= S_DQ_M2;
                S_DQ_M2:  r_state <= S_DQ_SUM;
                S_DQ_SUM: r_state <= S_COMMIT;
                S_COMMIT: begin
                    if (w_commit) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        // push: bump count and bytes of the target lane
                        if ((r_cmd == CMD_ENQ) && r_adm) begin
                            if (r_lane == LANE_CTL) begin
                                r_c_count <= r_c_count + CW'(1);
                                r_c_bytes <= r_c_bytes + BYTES_W'(r_sz);
                            end else begin
                                r_d_count <= r_d_count + CW'(1);
                                r_d_bytes <= r_d_bytes + BYTES_W'(r_sz);
                            end
                        end
                        // pop: advance head, drop count and bytes, fold the average
                        if ((r_cmd == CMD_DEQ) && r_dq_valid) begin
                            if (r_lane == LANE_CTL) begin
                                r_c_head  <= w_c_head_inc;
                                r_c_count <= r_c_count - CW'(1);
                                r_c_bytes <= r_c_bytes - BYTES_W'(r_s);
                            end else begin
                                r_d_head  <= w_d_head_inc;
                                r_d_count <= r_d_count - CW'(1);
                                r_d_bytes <= r_d_bytes - BYTES_W'(r_s);
                            end
                            r_rate <= r_new_rate;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working and output payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    r_cmd      <= i_command;
                    r_sz       <= w_sz_in;
                    r_ctl      <= i_is_control;
                    r_rel      <= i_is_reliable;
                    r_adm      <= 1'b0;
                    r_retry    <= '0;
                    r_dq_valid <= (r_c_count != '0) || (r_d_count != '0);
                    // dequeue serves control first
                    if (i_command == CMD_DEQ) begin
                        r_lane <= (r_c_count != '0) ? LANE_CTL : LANE_DATA;
                    end else begin
                        r_lane <= i_is_control ? LANE_CTL : LANE_DATA;
                    end
                end
            end
            S_EB_MUL: begin
                if (r_msg_limit == '0) begin
                    r_lim_msgs  <= '0;
                    r_lim_bytes <= '0;
                end
            end
            S_EB_DWT: begin
                if (w_div_stat.done) begin
                    r_lim_msgs  <= w_eff_msgs;
                    r_lim_bytes <= w_div_quo[BYTES_W-1:0];
                end
            end
            // headroom cut for unreliable data, keep factor in Q1.16
            S_UR_M2: r_lim_msgs  <= r_prod[FRAC_W+LIMIT_W-1:FRAC_W];
            S_UR_M3: r_lim_bytes <= r_prod[FRAC_W+BYTES_W-1:FRAC_W];
            S_ADM:   r_adm       <= w_adm;
            S_RT_DWT: begin
                if (w_div_stat.done) begin
                    r_retry <= w_retry_sat;
                end
            end
            S_DQ_RD:  r_s        <= w_rd16;
            S_DQ_M2:  r_t1       <= r_prod[PROD_W-2:0];
            S_DQ_SUM: r_new_rate <= w_rate_sat;
            S_COMMIT: begin
                if (w_commit) begin
                    r_out_admitted  <= (r_cmd == CMD_ENQ) && r_adm;
                    r_out_retry     <= (r_cmd == CMD_ENQ) ? r_retry : '0;
                    r_out_deq_valid <= (r_cmd == CMD_DEQ) && r_dq_valid;
                    r_out_deq_lane  <= (r_cmd == CMD_DEQ) && r_dq_valid && r_lane;
                    r_out_deq_bytes <= ((r_cmd == CMD_DEQ) && r_dq_valid) ? r_s : '0;
                end
            end
            default: ;
        endcase
    end

    // lane state changes only at commit, so it holds with the output word
    assign o_out_valid          = r_out_valid;
    assign o_admitted           = r_out_admitted;
    assign o_retry_ms           = r_out_retry;
    assign o_deq_valid          = r_out_deq_valid;
    assign o_deq_lane           = r_out_deq_lane;
    assign o_deq_bytes          = r_out_deq_bytes;
    assign o_control_count      = r_c_count;
    assign o_data_count         = r_d_count;
    assign o_control_byte_total = r_c_bytes;
    assign o_data_byte_total    = r_d_bytes;
    assign o_drain_rate         = r_rate;

    `TLQA_ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, (r_c_count <= DepthCnt) && (r_d_count <= DepthCnt))
    `TLQA_ASSERT_IMPLIES(a_ctl_empty_bytes, i_clk, i_rst_n, r_c_count == '0, r_c_bytes == '0)
    `TLQA_ASSERT_IMPLIES(a_dat_empty_bytes, i_clk, i_rst_n, r_d_count == '0, r_d_bytes == '0)
    `TLQA_ASSERT_IMPLIES(a_div_start_idle, i_clk, i_rst_n, w_div_start, !w_div_stat.busy)
    `TLQA_ASSERT_NEXT(a_commit_loads_out, i_clk, i_rst_n, w_commit, o_out_valid && !o_in_stall)

endmodule
